[design/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the section address translator: table
// geometry, opcodes, register indexes and the section entry layout.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int MAX_SECTIONS = 64;
    localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int LIMIT_W      = $clog2(MAX_SECTIONS + 1);

    localparam int ADDR_W       = 32;
    localparam int OPCODE_W     = 2;
    localparam int ENTRY_IDX_W  = 6;
    localparam int SEC_CNT_W    = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [ADDR_W-1:0] IMAGE_BASE_RESET = 32'h0040_0000;
    localparam logic [ADDR_W-1:0] REV_MISS         = '1;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FWD   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REV   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] virt_size;
        logic [ADDR_W-1:0] raw_offset;
        logic [ADDR_W-1:0] raw_size;
    } t_sec_entry;

    localparam int ENTRY_W = $bits(t_sec_entry);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

[design/section_address_translator.sv]
// ----------------------------------------------------------------------------
// section_address_translator
// Section table with forward (virtual to file) and reverse (file to virtual)
// address lookup, scanned one entry per cycle from a table RAM.
// ----------------------------------------------------------------------------
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+-----------------
//  command   | i_opcode, i_entry_*, i_query_addr            | start & !busy
//  result    | o_translated_addr, o_hit                     | o_valid, 1 cycle
//  config    | i_cfg_index, i_cfg_wdata                     | i_cfg_we
//
//  A write word or an unknown opcode returns its result the cycle after
//  acceptance and leaves busy low. A query over min(section_count,
//  MAX_SECTIONS) entries keeps busy high while it issues the first read, checks
//  the entries in turn and closes. The result strobes in the cycle in which
//  busy falls; a forward query stops at its first match.
//  Reset restores image_base and section_count; the table is not cleared.
//  The receiver cannot stall: o_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module section_address_translator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              start,
    output logic                              busy,
    input  logic [sat_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [sat_pkg::ENTRY_IDX_W-1:0]   i_entry_index,
    input  logic [sat_pkg::ADDR_W-1:0]        i_entry_virt_addr,
    input  logic [sat_pkg::ADDR_W-1:0]        i_entry_virt_size,
    input  logic [sat_pkg::ADDR_W-1:0]        i_entry_raw_offset,
    input  logic [sat_pkg::ADDR_W-1:0]        i_entry_raw_size,
    input  logic [sat_pkg::ADDR_W-1:0]        i_query_addr,

    output logic                              o_valid,
    output logic [sat_pkg::ADDR_W-1:0]        o_translated_addr,
    output logic                              o_hit,

    input  logic                              i_cfg_we,
    input  logic [sat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sat_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    import sat_pkg::*;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_image_base;
    logic [SEC_CNT_W-1:0] r_section_count;

    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_rev, n_rev;
    logic [LIMIT_W-1:0]   r_limit, n_limit;
    logic [LIMIT_W-1:0]   r_rd_idx, n_rd_idx;
    logic                 r_rd_live, n_rd_live;

    logic                 r_valid, n_valid;
    logic [ADDR_W-1:0]    r_res, n_res;
    logic                 r_hit, n_hit;

    logic                 accept;
    logic                 ram_we;
    t_sec_entry           wr_entry;
    logic [ENTRY_W-1:0]   rd_data;
    t_sec_entry           rd_entry;
    logic [LIMIT_W-1:0]   limit;
    logic [ADDR_W-1:0]    rebased;

    logic [ADDR_W-1:0]    cmp_lo;
    logic [ADDR_W-1:0]    cmp_hi;
    logic                 cmp_match;
    logic [ADDR_W-1:0]    cmp_value;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state == ST_SCAN);

    // table RAM: one write per write word, one read per scan cycle
    assign ram_we   = accept && (i_opcode == OP_WRITE)
                      && (int'(i_entry_index) < MAX_SECTIONS);
    assign wr_entry = '{virt_addr:  i_entry_virt_addr,
                        virt_size:  i_entry_virt_size,
                        raw_offset: i_entry_raw_offset,
                        raw_size:   i_entry_raw_size};

    sat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SECTIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IDX_W'(i_entry_index)),
        .i_wdata (wr_entry),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_entry = t_sec_entry'(rd_data);

    always_comb begin
        if (int'(r_section_count) > MAX_SECTIONS) begin
            limit = LIMIT_W'(MAX_SECTIONS);
        end else begin
            limit = LIMIT_W'(r_section_count);
        end
    end

    assign rebased = (i_query_addr > r_image_base) ? (i_query_addr - r_image_base)
                                                   : i_query_addr;

    // shared range check: forward uses the virtual range, reverse the raw one
    always_comb begin
        if (r_rev) begin
            cmp_lo    = rd_entry.raw_offset;
            cmp_hi    = rd_entry.raw_offset + rd_entry.raw_size;
            cmp_value = r_addr + rd_entry.virt_addr - rd_entry.raw_offset;
        end else begin
            cmp_lo    = rd_entry.virt_addr;
            cmp_hi    = rd_entry.virt_addr + rd_entry.virt_size;
            cmp_value = r_addr - rd_entry.virt_addr + rd_entry.raw_offset;
        end
        cmp_match = (r_addr >= cmp_lo) && (r_addr < cmp_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_base    <= IMAGE_BASE_RESET;
            r_section_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_BASE:    r_image_base    <= i_cfg_wdata[ADDR_W-1:0];
                CFG_SECTION_COUNT: r_section_count <= i_cfg_wdata[SEC_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_rd_live <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_rd_live <= n_rd_live;
        end
        r_addr   <= n_addr;
        r_rev    <= n_rev;
        r_limit  <= n_limit;
        r_rd_idx <= n_rd_idx;
        r_res    <= n_res;
        r_hit    <= n_hit;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_rev     = r_rev;
        n_limit   = r_limit;
        n_rd_idx  = r_rd_idx;
        n_rd_live = 1'b0;
        n_valid   = 1'b0;
        n_res     = r_res;
        n_hit     = r_hit;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_opcode == OP_FWD || i_opcode == OP_REV) begin
                        n_addr   = rebased;
                        n_rev    = (i_opcode == OP_REV);
                        n_limit  = limit;
                        n_rd_idx = '0;
                        n_res    = (i_opcode == OP_REV) ? REV_MISS : '0;
                        n_hit    = 1'b0;
                        if (limit == '0) begin
                            n_valid = 1'b1;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end else begin
                        // write word or unknown opcode: zero result
                        n_res   = '0;
                        n_hit   = 1'b0;
                        n_valid = 1'b1;
                    end
                end
            end

            ST_SCAN: begin
                // issue the next read while checking the previous one
                if (r_rd_idx < r_limit) begin
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_rd_live = 1'b1;
                end
                if (r_rd_live && cmp_match) begin
                    n_res = cmp_value;
                    n_hit = 1'b1;
                end
                priority if (r_rd_live && cmp_match && !r_rev) begin
                    // forward takes the first match: stop here
                    n_valid   = 1'b1;
                    n_rd_live = 1'b0;
                    n_state   = ST_IDLE;
                end else if (!r_rd_live && r_rd_idx == r_limit) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid           = r_valid;
    assign o_translated_addr = r_res;
    assign o_hit             = r_hit;

endmodule

[design/sat_ram.sv]
// ----------------------------------------------------------------------------
// sat_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[verif/section_address_translator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_address_translator_tb
// Self-checking bench for the section address translator. Table loads,
// forward and reverse lookups and unknown opcodes go in on the start/busy
// command port with random sender gaps. Every result strobe is compared with
// an in-bench lookup model, under a series of image base and section count
// settings.
// ----------------------------------------------------------------------------
module section_address_translator_tb;

    import sat_pkg::*;

    localparam logic [OPCODE_W-1:0]  OP_UNKNOWN  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int RANDOM_WORDS = 1700;

    typedef struct {
        logic [OPCODE_W-1:0]    op;
        logic [ENTRY_IDX_W-1:0] idx;
        logic [ADDR_W-1:0]      va;
        logic [ADDR_W-1:0]      vs;
        logic [ADDR_W-1:0]      raw;
        logic [ADDR_W-1:0]      rs;
        logic [ADDR_W-1:0]      qa;
    } t_sec_word;

    typedef struct {
        logic [ADDR_W-1:0]   addr;
        logic                hit;
        logic [OPCODE_W-1:0] op;
    } t_xlat;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [OPCODE_W-1:0]    i_opcode = '0;
    logic [ENTRY_IDX_W-1:0] i_entry_index = '0;
    logic [ADDR_W-1:0]      i_entry_virt_addr = '0;
    logic [ADDR_W-1:0]      i_entry_virt_size = '0;
    logic [ADDR_W-1:0]      i_entry_raw_offset = '0;
    logic [ADDR_W-1:0]      i_entry_raw_size = '0;
    logic [ADDR_W-1:0]      i_query_addr = '0;
    logic                   o_valid;
    logic [ADDR_W-1:0]      o_translated_addr;
    logic                   o_hit;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    section_address_translator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_entry_index      (i_entry_index),
        .i_entry_virt_addr  (i_entry_virt_addr),
        .i_entry_virt_size  (i_entry_virt_size),
        .i_entry_raw_offset (i_entry_raw_offset),
        .i_entry_raw_size   (i_entry_raw_size),
        .i_query_addr       (i_query_addr),
        .o_valid            (o_valid),
        .o_translated_addr  (o_translated_addr),
        .o_hit              (o_hit),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lookup model state, updated as words are accepted
    logic [ADDR_W-1:0]    base_m = IMAGE_BASE_RESET;
    logic [SEC_CNT_W-1:0] count_m = '0;
    logic [ADDR_W-1:0]    tbl_va  [MAX_SECTIONS];
    logic [ADDR_W-1:0]    tbl_vs  [MAX_SECTIONS];
    logic [ADDR_W-1:0]    tbl_raw [MAX_SECTIONS];
    logic [ADDR_W-1:0]    tbl_rs  [MAX_SECTIONS];

    // Section layout as the stimulus has planned it, ahead of the block
    logic [ADDR_W-1:0]    lay_va  [MAX_SECTIONS];
    logic [ADDR_W-1:0]    lay_vs  [MAX_SECTIONS];
    logic [ADDR_W-1:0]    lay_raw [MAX_SECTIONS];
    logic [ADDR_W-1:0]    lay_rs  [MAX_SECTIONS];
    bit                   lay_set [MAX_SECTIONS];

    t_sec_word pending_words[$];
    t_xlat     pending_results[$];
    t_sec_word cur_word;

    int  gap_left = 0;
    int  idle_pct = 0;
    bit  calm = 1'b0;
    int  errors = 0;
    int  n_words = 0;
    int  n_writes = 0;
    int  n_fwd = 0;
    int  n_rev = 0;
    int  n_hits = 0;
    int  n_settings = 0;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int scan_limit();
        return (count_m > MAX_SECTIONS) ? MAX_SECTIONS : int'(count_m);
    endfunction

    function automatic t_xlat translate_word(t_sec_word w);
        t_xlat r;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        int n;
        r.addr = '0;
        r.hit  = 1'b0;
        r.op   = w.op;
        n = scan_limit();
        a = (w.qa > base_m) ? w.qa - base_m : w.qa;
        case (w.op)
            OP_WRITE: begin
                if (w.idx < MAX_SECTIONS) begin
                    tbl_va[w.idx]  = w.va;
                    tbl_vs[w.idx]  = w.vs;
                    tbl_raw[w.idx] = w.raw;
                    tbl_rs[w.idx]  = w.rs;
                end
            end
            OP_FWD: begin
                // first section holding the address wins
                for (int i = 0; i < n; i++) begin
                    lo = tbl_va[i];
                    hi = lo + tbl_vs[i];
                    if (a >= lo && a < hi) begin
                        r.addr = a - lo + tbl_raw[i];
                        r.hit  = 1'b1;
                        break;
                    end
                end
            end
            OP_REV: begin
                // last matching raw range wins
                r.addr = REV_MISS;
                for (int i = 0; i < n; i++) begin
                    lo = tbl_raw[i];
                    hi = lo + tbl_rs[i];
                    if (a >= lo && a < hi) begin
                        r.addr = a + tbl_va[i] - lo;
                        r.hit  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: offer the oldest pending word, hold it until accepted
    always @(posedge i_clk) begin : drive_proc
        logic  take;
        logic  nxt;
        t_xlat r;
        take = start && !busy;
        nxt  = start && !take;
        if (!i_rst_n) begin
            nxt = 1'b0;
        end else begin
            if (take) begin
                r = translate_word(cur_word);
                pending_results = {pending_results, r};
                n_words++;
                n_hits += r.hit;
                if (cur_word.op == OP_WRITE) n_writes++;
                if (cur_word.op == OP_FWD) n_fwd++;
                if (cur_word.op == OP_REV) n_rev++;
                if (!calm && $urandom_range(0, 99) < idle_pct)
                    gap_left = $urandom_range(1, 15);
            end
            if (!nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    i_opcode           <= cur_word.op;
                    i_entry_index      <= cur_word.idx;
                    i_entry_virt_addr  <= cur_word.va;
                    i_entry_virt_size  <= cur_word.vs;
                    i_entry_raw_offset <= cur_word.raw;
                    i_entry_raw_size   <= cur_word.rs;
                    i_query_addr       <= cur_word.qa;
                    nxt = 1'b1;
                end
            end
        end
        start <= nxt;
    end

    // Monitor: each strobe retires the oldest expected result
    always @(posedge i_clk) begin : check_proc
        t_xlat want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result %h/%b with no word pending",
                                        o_translated_addr, o_hit));
            end else begin
                want = pending_results.pop_front();
                if (o_translated_addr !== want.addr)
                    flag_mismatch($sformatf("op %0d: translated_addr %h, expected %h",
                                            want.op, o_translated_addr, want.addr));
                if (o_hit !== want.hit)
                    flag_mismatch($sformatf("op %0d: hit %b, expected %b",
                                            want.op, o_hit, want.hit));
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_BASE) base_m = data;
        else if (idx == CFG_SECTION_COUNT) count_m = data[SEC_CNT_W-1:0];
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || start || pending_results.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    task automatic push_cmd(input logic [OPCODE_W-1:0] op, input logic [ENTRY_IDX_W-1:0] idx,
                            input logic [ADDR_W-1:0] va, input logic [ADDR_W-1:0] vs,
                            input logic [ADDR_W-1:0] raw, input logic [ADDR_W-1:0] rs,
                            input logic [ADDR_W-1:0] qa);
        t_sec_word w;
        w.op = op;
        w.idx = idx;
        w.va = va;
        w.vs = vs;
        w.raw = raw;
        w.rs = rs;
        w.qa = qa;
        pending_words = {pending_words, w};
        if (op == OP_WRITE && idx < MAX_SECTIONS) begin
            lay_va[idx]  = va;
            lay_vs[idx]  = vs;
            lay_raw[idx] = raw;
            lay_rs[idx]  = rs;
            lay_set[idx] = 1'b1;
        end
    endtask

    task automatic push_entry(input int idx);
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] vs;
        logic [ADDR_W-1:0] raw;
        logic [ADDR_W-1:0] rs;
        // mostly packed small sections so that ranges overlap; the rest wild
        if ($urandom_range(0, 9) < 7) begin
            va  = $urandom & 32'h000F_F000;
            vs  = $urandom_range(1, 32'h0002_0000);
            raw = $urandom & 32'h000F_FE00;
            rs  = $urandom_range(0, 32'h0002_0000);
        end else begin
            va  = $urandom;
            vs  = $urandom;
            raw = $urandom;
            rs  = $urandom;
        end
        push_cmd(OP_WRITE, ENTRY_IDX_W'(idx), va, vs, raw, rs, $urandom);
    endtask

    // Aim a lookup at a planned section, its edges or just past them, or at a random address
    function automatic logic [ADDR_W-1:0] aim_query(input logic [OPCODE_W-1:0] op, input int lim);
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] sz;
        logic [ADDR_W-1:0] t;
        int i;
        if (lim == 0 || $urandom_range(0, 99) < 25) begin
            case ($urandom_range(0, 5))
                0:       return '0;
                1:       return '1;
                default: return $urandom;
            endcase
        end
        i  = $urandom_range(0, lim - 1);
        lo = (op == OP_FWD) ? lay_va[i] : lay_raw[i];
        sz = (op == OP_FWD) ? lay_vs[i] : lay_rs[i];
        case ($urandom_range(0, 5))
            0:       t = lo;
            1:       t = lo + sz - 1;
            2:       t = lo + sz;
            3:       t = lo - 1;
            default: t = lo + ((sz == 0) ? '0 : $urandom % sz);
        endcase
        if ($urandom_range(0, 2) == 0) t = t + base_m;
        return t;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return IMAGE_BASE_RESET;
            3:       return $urandom & 32'h00FF_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, 8);
        if (r < 60) return $urandom_range(9, 63);
        if (r < 75) return MAX_SECTIONS;
        if (r < 82) return MAX_SECTIONS + 1;
        if (r < 88) return 32'd127;
        return $urandom;
    endfunction

    initial begin : stim_proc
        int sent;
        int lim;
        int len;
        int r;
        int idx;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 30;

        // reset settings: empty table scan, then load a few sections
        push_cmd(OP_FWD, 0, 0, 0, 0, 0, 32'h0000_0000);
        push_cmd(OP_REV, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_cmd(OP_UNKNOWN, '1, '1, '1, '1, '1, '1);
        push_cmd(OP_WRITE, 0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0400, 32'h0000_2000, 0);
        push_cmd(OP_WRITE, 1, 32'h0000_1800, 32'h0000_1000, 32'h0000_0600, 32'h0000_0800, 0);
        // both ranges of this one wrap past the top
        push_cmd(OP_WRITE, 2, 32'hFFFF_F000, 32'h0000_2000, 32'hFFFF_FF00, 32'h0000_0100, 0);
        push_cmd(OP_WRITE, 3, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 0);
        push_cmd(OP_WRITE, 63, '1, '1, '1, '1, '1);
        wait_idle();

        write_reg(CFG_IMAGE_BASE, 32'h0000_0000);
        write_reg(CFG_SECTION_COUNT, 32'hFFFF_FF84);  // only the low bits count
        write_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_3, 32'h0000_0001);
        push_cmd(OP_FWD, 0, 0, 0, 0, 0, 32'h0000_1000);
        push_cmd(OP_FWD, 0, 0, 0, 0, 0, 32'h0000_2FFF);
        push_cmd(OP_FWD, 0, 0, 0, 0, 0, 32'h0000_3000);
        push_cmd(OP_FWD, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_cmd(OP_REV, 0, 0, 0, 0, 0, 32'h0000_0600);
        push_cmd(OP_REV, 0, 0, 0, 0, 0, 32'h0000_0DFF);
        push_cmd(OP_REV, 0, 0, 0, 0, 0, 32'h0000_03FF);
        push_cmd(OP_REV, 0, 0, 0, 0, 0, 32'h0000_23FF);
        wait_idle();

        write_reg(CFG_IMAGE_BASE, 32'h0000_1000);
        push_cmd(OP_FWD, 0, 0, 0, 0, 0, 32'h0000_2000);
        push_cmd(OP_FWD, 0, 0, 0, 0, 0, 32'h0000_1000);
        push_cmd(OP_REV, 0, 0, 0, 0, 0, 32'h0000_1400);
        wait_idle();

        write_reg(CFG_IMAGE_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_SECTION_COUNT, 32'd2);
        push_cmd(OP_FWD, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_cmd(OP_REV, 0, 0, 0, 0, 0, 32'h0000_0700);
        push_cmd(OP_UNKNOWN, 0, 0, 0, 0, 0, 0);
        wait_idle();
        n_settings = 4;

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            write_reg(CFG_IMAGE_BASE, pick_base());
            write_reg(CFG_SECTION_COUNT, pick_count());
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
            n_settings++;
            calm = (sent >= RANDOM_WORDS * 85 / 100);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            lim = scan_limit();
            // load every slot the scan will reach before any lookup
            for (int i = 0; i < lim; i++)
                if (!lay_set[i]) push_entry(i);
            len = $urandom_range(30, 100);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    idx = (lim > 0 && $urandom_range(0, 1)) ? $urandom_range(0, lim - 1)
                                                            : $urandom_range(0, MAX_SECTIONS - 1);
                    push_entry(idx);
                end else if (r < 60) begin
                    push_cmd(OP_FWD, ENTRY_IDX_W'($urandom_range(0, 63)), $urandom, $urandom,
                             $urandom, $urandom, aim_query(OP_FWD, lim));
                end else if (r < 95) begin
                    push_cmd(OP_REV, ENTRY_IDX_W'($urandom_range(0, 63)), $urandom, $urandom,
                             $urandom, $urandom, aim_query(OP_REV, lim));
                end else begin
                    push_cmd(OP_UNKNOWN, ENTRY_IDX_W'($urandom_range(0, 63)), $urandom,
                             $urandom, $urandom, $urandom, $urandom);
                end
            end
            sent += len;
            wait_idle();
        end

        repeat (MAX_SECTIONS + 8) @(posedge i_clk);
        $display("Covered %0d words: %0d table loads, %0d forward, %0d reverse, %0d hits",
                 n_words, n_writes, n_fwd, n_rev, n_hits);
        $display("across %0d register settings, %0d mismatches", n_settings, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
design/sat_pkg.sv
design/sat_ram.sv
design/section_address_translator.sv
verif/section_address_translator_tb.sv
